FILE: hdl/spi_flash_command_sequencer_unit_defines.svh
// Assertion macros used by the result register of the SPI flash command sequencer RTL.
`ifndef SPI_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH
`define SPI_FLASH_COMMAND_SEQUENCER_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SFCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sfcs assertion failed");

// Check that cons holds in the cycle after ante.
`define SFCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sfcs assertion failed");

`endif

FILE: hdl/sfcs_pkg.sv
// Types, codes and helper functions of the SPI flash command sequencer.
`default_nettype none
package sfcs_pkg;

  localparam int unsigned PageBytesDefault  = 256;
  localparam int unsigned FlashBytesDefault = 16777216;

  typedef enum logic [2:0] {
    REQ_ERASE_SECTOR = 3'd0,
    REQ_ERASE_CHIP   = 3'd1,
    REQ_PROGRAM      = 3'd2,
    REQ_WRITE        = 3'd3,
    REQ_READ         = 3'd4,
    REQ_STATUS       = 3'd5,
    REQ_STATUS_REPLY = 3'd6,
    REQ_XFER_DONE    = 3'd7
  } sfcs_req_e;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_DONE   = 2'd1,
    KIND_REJECT = 2'd2
  } sfcs_kind_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_POLL = 3'b010,
    PH_SEND = 3'b100
  } sfcs_phase_e;

  localparam logic [7:0] OpReadSr1     = 8'h05;
  localparam logic [7:0] OpReadSr2     = 8'h35;
  localparam logic [7:0] OpReadSr3     = 8'h15;
  localparam logic [7:0] OpWriteEnable = 8'h06;
  localparam logic [7:0] OpSectorErase = 8'h20;
  localparam logic [7:0] OpChipErase   = 8'hC7;
  localparam logic [7:0] OpPageProgram = 8'h02;
  localparam logic [7:0] OpRead        = 8'h03;

  localparam int unsigned BusyBit = 0;
  localparam int unsigned WelBit  = 1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [23:0] address;
    logic [24:0] byte_count;
    logic [7:0]  status_one;
    logic [7:0]  status_two;
    logic [7:0]  status_three;
  } sfcs_in_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  opcode;
    logic [23:0] frame_address;
    logic        address_used;
    logic [8:0]  tx_data_count;
    logic [24:0] rx_data_count;
    logic [23:0] status_regs;
    logic        last;
  } sfcs_out_t;

  // Up to three results caused by one input item.
  typedef struct packed {
    logic [1:0]           count;
    sfcs_out_t [2:0]      item;
  } sfcs_bundle_t;

  function automatic sfcs_out_t mk_frame(logic [7:0] op, logic [23:0] fa, logic au,
                                         logic [8:0] tx, logic [24:0] rx);
    sfcs_out_t r;
    r.result_kind   = KIND_FRAME;
    r.opcode        = op;
    r.frame_address = fa;
    r.address_used  = au;
    r.tx_data_count = tx;
    r.rx_data_count = rx;
    r.status_regs   = 24'd0;
    r.last          = 1'b0;
    return r;
  endfunction

  function automatic sfcs_out_t mk_host(sfcs_kind_e kind, logic [23:0] st);
    sfcs_out_t r;
    r               = '0;
    r.result_kind   = kind;
    r.status_regs   = st;
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/sfcs_core.sv
// Sequencer state and the single-pass logic that turns one item into its results.
`default_nettype none
module sfcs_core
  import sfcs_pkg::*;
#(
  parameter int unsigned PAGE_BYTES  = PageBytesDefault,
  parameter int unsigned FLASH_BYTES = FlashBytesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         adv_i,
  input  sfcs_in_t     item_i,
  output sfcs_bundle_t bundle_o
);

  localparam logic [8:0]  PageLen  = 9'(PAGE_BYTES);
  localparam logic [8:0]  PageMask = 9'(PAGE_BYTES - 1);
  localparam logic [24:0] FlashLen = 25'(FLASH_BYTES);

  sfcs_phase_e phase_q, phase_d;
  sfcs_req_e   op_q, op_d;
  logic [23:0] addr_q, addr_d;
  logic [24:0] left_q, left_d;
  logic [8:0]  chunk_q, chunk_d;
  logic [23:0] status_q, status_d;

  sfcs_req_e   req;
  logic [24:0] room, wr_len;
  logic [8:0]  prog_len, rel, space, chunk_new, step;
  logic [24:0] left_after;
  logic [23:0] status_new;
  sfcs_out_t   op_frame;
  logic        op_wel;
  sfcs_bundle_t bnd;

  assign req = sfcs_req_e'(item_i.req_type);

  // Request sizing: clamp writes at the flash end, programs at one page.
  assign room     = ({1'b0, item_i.address} >= FlashLen) ? 25'd0
                                                         : FlashLen - {1'b0, item_i.address};
  assign wr_len   = (item_i.byte_count > room) ? room : item_i.byte_count;
  assign prog_len = (item_i.byte_count > {16'd0, PageLen}) ? PageLen
                                                           : item_i.byte_count[8:0];

  // Page split of a write piece.
  assign rel       = {1'b0, addr_q[7:0]} & PageMask;
  assign space     = PageLen - rel;
  assign chunk_new = (left_q > {16'd0, space}) ? space : left_q[8:0];

  // Advance of a write after its piece is sent.
  assign step       = ({16'd0, chunk_q} > left_q) ? left_q[8:0] : chunk_q;
  assign left_after = left_q - {16'd0, step};

  assign status_new = {item_i.status_three, item_i.status_two, item_i.status_one};

  // Operation frame sent once the flash reads not busy.
  always_comb begin
    op_wel   = ~status_new[WelBit];
    case (op_q)
      REQ_ERASE_SECTOR: op_frame = mk_frame(OpSectorErase, addr_q, 1'b1, 9'd0, 25'd0);
      REQ_ERASE_CHIP:   op_frame = mk_frame(OpChipErase, 24'd0, 1'b0, 9'd0, 25'd0);
      REQ_WRITE:        op_frame = mk_frame(OpPageProgram, addr_q, 1'b1, chunk_new, 25'd0);
      REQ_READ: begin
        op_frame = mk_frame(OpRead, addr_q, 1'b1, 9'd0, left_q);
        op_wel   = 1'b0;
      end
      default:          op_frame = mk_frame(OpPageProgram, addr_q, 1'b1, chunk_q, 25'd0);
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    op_d     = op_q;
    addr_d   = addr_q;
    left_d   = left_q;
    chunk_d  = chunk_q;
    status_d = status_q;
    bnd      = '0;
    case (req)
      REQ_ERASE_SECTOR, REQ_ERASE_CHIP, REQ_PROGRAM, REQ_WRITE, REQ_READ, REQ_STATUS: begin
        if (phase_q != PH_IDLE) begin
          bnd.item[0] = mk_host(KIND_REJECT, 24'd0);
          bnd.count   = 2'd1;
        end else begin
          op_d    = req;
          addr_d  = item_i.address;
          left_d  = 25'd0;
          chunk_d = 9'd0;
          if (req == REQ_PROGRAM) chunk_d = prog_len;
          if (req == REQ_WRITE)   left_d  = wr_len;
          if (req == REQ_READ)    left_d  = item_i.byte_count;
          if (req == REQ_WRITE && wr_len == 25'd0) begin
            bnd.item[0] = mk_host(KIND_DONE, status_q);
            bnd.count   = 2'd1;
            phase_d     = PH_IDLE;
          end else begin
            bnd.item[0] = mk_frame(OpReadSr1, 24'd0, 1'b0, 9'd0, 25'd1);
            bnd.item[1] = mk_frame(OpReadSr2, 24'd0, 1'b0, 9'd0, 25'd1);
            bnd.item[2] = mk_frame(OpReadSr3, 24'd0, 1'b0, 9'd0, 25'd1);
            bnd.count   = 2'd3;
            phase_d     = PH_POLL;
          end
        end
      end
      REQ_STATUS_REPLY: begin
        if (phase_q == PH_POLL) begin
          status_d = status_new;
          if (op_q == REQ_STATUS) begin
            bnd.item[0] = mk_host(KIND_DONE, status_new);
            bnd.count   = 2'd1;
            phase_d     = PH_IDLE;
          end else if (item_i.status_one[BusyBit]) begin
            bnd.item[0] = mk_frame(OpReadSr1, 24'd0, 1'b0, 9'd0, 25'd1);
            bnd.item[1] = mk_frame(OpReadSr2, 24'd0, 1'b0, 9'd0, 25'd1);
            bnd.item[2] = mk_frame(OpReadSr3, 24'd0, 1'b0, 9'd0, 25'd1);
            bnd.count   = 2'd3;
          end else begin
            if (op_q == REQ_WRITE) chunk_d = chunk_new;
            if (op_wel) begin
              bnd.item[0] = mk_frame(OpWriteEnable, 24'd0, 1'b0, 9'd0, 25'd0);
              bnd.item[1] = op_frame;
              bnd.count   = 2'd2;
            end else begin
              bnd.item[0] = op_frame;
              bnd.count   = 2'd1;
            end
            phase_d = PH_SEND;
          end
        end
      end
      REQ_XFER_DONE: begin
        if (phase_q == PH_SEND) begin
          if (op_q == REQ_WRITE && left_after != 25'd0) begin
            left_d      = left_after;
            addr_d      = addr_q + {15'd0, step};
            bnd.item[0] = mk_frame(OpReadSr1, 24'd0, 1'b0, 9'd0, 25'd1);
            bnd.item[1] = mk_frame(OpReadSr2, 24'd0, 1'b0, 9'd0, 25'd1);
            bnd.item[2] = mk_frame(OpReadSr3, 24'd0, 1'b0, 9'd0, 25'd1);
            bnd.count   = 2'd3;
            phase_d     = PH_POLL;
          end else begin
            if (op_q == REQ_WRITE) begin
              left_d = left_after;
              addr_d = addr_q + {15'd0, step};
            end
            bnd.item[0] = mk_host(KIND_DONE, status_q);
            bnd.count   = 2'd1;
            phase_d     = PH_IDLE;
          end
        end
      end
      default: ;
    endcase
    // Mark the final result of the item.
    for (int i = 0; i < 3; i++) begin
      bnd.item[i].last = ((2'(i) + 2'd1) == bnd.count);
    end
  end

  assign bundle_o = bnd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      op_q     <= REQ_ERASE_SECTOR;
      addr_q   <= 24'd0;
      left_q   <= 25'd0;
      chunk_q  <= 9'd0;
      status_q <= 24'd0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      op_q     <= op_d;
      addr_q   <= addr_d;
      left_q   <= left_d;
      chunk_q  <= chunk_d;
      status_q <= status_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/sfcs_out_buf.sv
// Result register that holds one item's results and hands them out one per transaction.
`default_nettype none
`include "spi_flash_command_sequencer_unit_defines.svh"
module sfcs_out_buf
  import sfcs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  sfcs_bundle_t bundle_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output sfcs_out_t    out_data_o
);

  sfcs_bundle_t bundle_q;
  logic [1:0]   idx_q, idx_d;
  logic         valid_q, valid_d;
  sfcs_out_t    cur;
  logic         drain;

  assign cur         = bundle_q.item[idx_q];
  assign drain       = valid_q & ~out_stall_i;
  assign free_o      = ~valid_q | (drain & cur.last);
  assign out_valid_o = valid_q;
  assign out_data_o  = cur;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load_i) begin
      valid_d = 1'b1;
      idx_d   = 2'd0;
    end else if (drain && cur.last) begin
      valid_d = 1'b0;
    end else if (drain) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) bundle_q <= bundle_i;
  end

  `SFCS_ASSERT_NOW(a_load_when_free, load_i, free_o && bundle_i.count != 2'd0)
  `SFCS_ASSERT_NOW(a_idx_in_bundle, valid_q, idx_q < bundle_q.count)
  `SFCS_ASSERT_NEXT(a_last_drains, drain && cur.last && !load_i, !valid_q)
  `SFCS_ASSERT_NEXT(a_mid_advances, drain && !cur.last, valid_q && idx_q == $past(idx_q) + 2'd1)

endmodule
`default_nettype wire

FILE: hdl/spi_flash_command_sequencer_unit.sv
// Top level of the SPI flash command sequencer: input register, sequencer core, result register.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+--------------------------------
//  in      | to block  | in_valid_i/in_stall_o  | sfcs_in_t: request or flash reply
//  out     | from block| out_valid_o/out_stall_i| sfcs_out_t: SPI frame or host result
//
// Cycles: one item is accepted per clock unless a held item waits on a busy result register;
//   its state update and all results (up to three) form in the cycle it leaves the input register.
// Results leave one per output transaction, so an item causing n results occupies the result
//   register until its n results leave; items causing no result never load it but wait until it is free.
// Stalls: the input register holds one item while the result register waits on the sink, then
//   stalls the input until the last result leaves, which frees the register in that same cycle.
// Reset: rst_ni is asynchronous, active low, and clears phase, sequencer state and valids.
`default_nettype none
module spi_flash_command_sequencer_unit
  import sfcs_pkg::*;
#(
  parameter int unsigned PAGE_BYTES  = PageBytesDefault,  // power of two, 16 to 256
  parameter int unsigned FLASH_BYTES = FlashBytesDefault  // 65536 to 16777216
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  sfcs_in_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output sfcs_out_t out_data_o
);

  sfcs_in_t     in_q;
  logic         in_vq, in_vd;
  logic         in_take;
  logic         adv;
  logic         buf_free;
  sfcs_bundle_t bundle;

  // Advance the held item once the result register can take its results.
  assign adv        = in_vq & buf_free;
  assign in_stall_o = in_vq & ~adv;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign in_vd      = in_take | (in_vq & ~adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else begin
      in_vq <= in_vd;
    end
  end

  // Hold the payload; no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_take) in_q <= in_data_i;
  end

  sfcs_core #(
    .PAGE_BYTES  (PAGE_BYTES),
    .FLASH_BYTES (FLASH_BYTES)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .item_i   (in_q),
    .bundle_o (bundle)
  );

  // Drop items that cause no result; load the rest.
  sfcs_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && bundle.count != 2'd0),
    .bundle_i    (bundle),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
`default_nettype wire
